@@ hw/rtl/apu_pkg.sv @@
// Shared types and constants of the Adam parameter update block.
// Used by the top level and by its port checker; depends on nothing else.
package apu_pkg;

  localparam int FRAC_BITS   = 24;
  localparam int PARAM_COUNT = 65536;
  localparam int IDX_W       = $clog2(PARAM_COUNT);
  localparam int CFG_W       = 24;
  localparam int STEP_W      = 20;
  localparam int EXP_W       = STEP_W + 1;

  localparam logic [FRAC_BITS:0]   ONE_Q  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS-1:0] HALF_Q = {1'b1, {(FRAC_BITS - 1){1'b0}}};

  localparam logic [CFG_W-1:0] BETA_FIRST_RST    = 24'd15099494;
  localparam logic [CFG_W-1:0] BETA_SECOND_RST   = 24'd16760439;
  localparam logic [CFG_W-1:0] LEARNING_RATE_RST = 24'd167772;
  localparam logic [CFG_W-1:0] EPSILON_TERM_RST  = 24'd2;

  typedef enum logic [1:0] {
    CFG_BETA_FIRST    = 2'd0,
    CFG_BETA_SECOND   = 2'd1,
    CFG_LEARNING_RATE = 2'd2,
    CFG_EPSILON_TERM  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [IDX_W-1:0]  param_index;
    logic signed [31:0] gradient;
    logic signed [31:0] weight;
    logic [STEP_W-1:0] step_number;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_weight;
    logic               saturated;
  } out_item_t;

endpackage

@@ hw/rtl/adam_parameter_update.sv @@
// Adam parameter update: moment stores, bias correction, divide and square root pipeline.
// Depends on apu_pkg for the request and result types and the register defaults.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one parameter request per cycle
//   while in_stall is low: index, gradient, current weight and step number. The result channel
//   (out_valid / out_stall / out_data) returns the updated weight and a saturation flag,
//   one result per request, in request order.
//   Throughput is one request per clock while in_stall is low. The pipeline depth is set by
//   the 21-step power pipeline followed by the long-division and square-root stages,
//   two result bits per stage.
//   Requests to the same index may follow back to back: the moment update stage forwards
//   its own last result to the next request.
//   The configuration port (cfg_we / cfg_index / cfg_wdata) is to be written only while no
//   request is in flight; the block itself does not enforce this.
//   After reset the moment stores are zeroed by a clearing pass over every index; in_stall
//   stays high during that pass. Registers return to their default values.
//   When the receiver stalls a waiting result, the whole pipeline holds and in_stall rises;
//   nothing is dropped or repeated.
module adam_parameter_update (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  apu_pkg::in_item_t      in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output apu_pkg::out_item_t     out_data,
  input  logic                   cfg_we,
  input  apu_pkg::cfg_idx_t      cfg_index,
  input  logic [apu_pkg::CFG_W-1:0] cfg_wdata
);
  import apu_pkg::*;

  localparam int S_VPR   = 3;
  localparam int S_MOM   = 4;
  localparam int S_ABS   = 5;
  localparam int S_CORR  = EXP_W + 1;
  localparam int D1_STG  = 28;
  localparam int D2_STG  = 32;
  localparam int S_SQI   = S_CORR + D2_STG + 1;
  localparam int SQ_STG  = 16;
  localparam int S_DEN   = S_SQI + SQ_STG + 1;
  localparam int S_SCMP  = S_DEN + 1;
  localparam int D3_STG  = 16;
  localparam int S_OUT   = S_SCMP + D3_STG + 1;
  localparam int DEPTH   = S_OUT + 1;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] g;
    logic signed [31:0] w;
    logic [EXP_W-1:0]   e;
    logic [24:0]        pr1;
    logic [24:0]        pr2;
    logic [23:0]        pb1;
    logic [23:0]        pb2;
    logic [62:0]        gg;
    logic signed [57:0] c1g;
    logic [46:0]        gsq;
    logic [49:0]        pvlo;
    logic [47:0]        pvhi;
    logic signed [31:0] mn;
    logic [47:0]        vn;
    logic               sat;
    logic               neg;
    logic [31:0]        am;
    logic [24:0]        corr1;
    logic [24:0]        corr2;
    logic [55:0]        n1;
    logic [55:0]        q1;
    logic [24:0]        rem1;
    logic [24:0]        rem2;
    logic [63:0]        n2;
    logic [63:0]        q2;
    logic               vsat;
    logic [33:0]        rs;
    logic [31:0]        root;
    logic [63:0]        sqn;
    logic [55:0]        phi;
    logic [47:0]        plo;
    logic [56:0]        a;
    logic [40:0]        den;
    logic [40:0]        rem3;
    logic [31:0]        n3;
    logic [31:0]        q3;
    logic               ssat;
    logic signed [31:0] nw;
  } stage_t;

  logic [CFG_W-1:0] b1_r, b2_r, lr_r, eps_r;
  logic [IDX_W:0]   clr_cnt_r;
  logic             clearing;
  logic             adv;
  logic             v_r [DEPTH];
  stage_t           pipe_r [DEPTH];
  stage_t           pipe_nxt [DEPTH];

  logic signed [31:0] m_mem [PARAM_COUNT];
  logic [47:0]        v_mem [PARAM_COUNT];
  logic signed [31:0] m_rd_r;
  logic [47:0]        v_rd_r;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa;
  logic signed [31:0] m_new;
  logic [47:0]        v_new;
  logic               mom_sat;
  logic               fwd;
  logic signed [31:0] m_old;
  logic [47:0]        v_old;
  logic signed [58:0] m_sum;
  logic [34:0]        m_hi;
  logic [50:0]        v_lo_sum;
  logic [48:0]        v_hi_sum;
  logic [49:0]        v_full;
  logic [24:0]        c1, c2;

  function automatic logic [24:0] mulq(input logic [24:0] x, input logic [23:0] y);
    logic [48:0] p;
    p = {24'b0, x} * {25'b0, y} + {25'b0, HALF_Q};
    return p[48:24];
  endfunction

  // one restoring divide step: {remainder, quotient bit}
  function automatic logic [41:0] dstep(input logic [40:0] rem, input logic nb,
                                        input logic [40:0] d);
    logic [41:0] t;
    t = {rem, nb};
    if (t >= {1'b0, d}) begin
      return {41'(t - {1'b0, d}), 1'b1};
    end else begin
      return {t[40:0], 1'b0};
    end
  endfunction

  // one digit of the square root: {remainder, root}
  function automatic logic [65:0] sqstep(input logic [33:0] rs, input logic [31:0] root,
                                         input logic [1:0] nb);
    logic [35:0] t;
    logic [35:0] trial;
    t = {rs, nb};
    trial = {2'b0, root, 2'b01};
    if (t >= trial) begin
      return {34'(t - trial), root[30:0], 1'b1};
    end else begin
      return {t[33:0], root[30:0], 1'b0};
    end
  endfunction

  assign clearing  = !clr_cnt_r[IDX_W];
  assign adv       = !(v_r[S_OUT] && out_stall);
  assign in_stall  = !adv || clearing;
  assign out_valid = v_r[S_OUT];
  assign out_data.new_weight = pipe_r[S_OUT].nw;
  assign out_data.saturated  = pipe_r[S_OUT].sat;

  assign c1 = ONE_Q - {1'b0, b1_r};
  assign c2 = ONE_Q - {1'b0, b2_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_r  <= BETA_FIRST_RST;
      b2_r  <= BETA_SECOND_RST;
      lr_r  <= LEARNING_RATE_RST;
      eps_r <= EPSILON_TERM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BETA_FIRST:    b1_r  <= cfg_wdata;
        CFG_BETA_SECOND:   b2_r  <= cfg_wdata;
        CFG_LEARNING_RATE: lr_r  <= cfg_wdata;
        CFG_EPSILON_TERM:  eps_r <= cfg_wdata;
        default:           b1_r  <= b1_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (clearing) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DEPTH; k++) v_r[k] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid && !clearing;
      for (int k = 1; k < DEPTH; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pipe_r <= pipe_nxt;
    end
  end

  // moment update loop; forward the previous result on a repeated index
  assign fwd   = v_r[S_MOM] && (pipe_r[S_MOM].idx == pipe_r[S_VPR].idx);
  assign m_old = fwd ? pipe_r[S_MOM].mn : m_rd_r;
  assign v_old = fwd ? pipe_r[S_MOM].vn : v_rd_r;

  always_comb begin
    m_sum    = $signed({1'b0, b1_r}) * m_old + pipe_r[S_VPR].c1g;
    m_hi     = m_sum[58:24];
    v_lo_sum = {27'b0, b2_r} * {27'b0, v_old[23:0]} + {1'b0, pipe_r[S_VPR].pvlo};
    v_hi_sum = {25'b0, b2_r} * {25'b0, v_old[47:24]} + {1'b0, pipe_r[S_VPR].pvhi};
    v_full   = {1'b0, v_hi_sum} + {23'b0, v_lo_sum[50:24]};
    mom_sat  = 1'b0;
    if (m_hi[34:31] != 4'b0000 && m_hi[34:31] != 4'b1111) begin
      m_new   = m_hi[34] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      mom_sat = 1'b1;
    end else begin
      m_new = m_hi[31:0];
    end
    if (v_full[49:48] != 2'b00) begin
      v_new   = '1;
      mom_sat = 1'b1;
    end else begin
      v_new = v_full[47:0];
    end
  end

  assign mem_we = clearing || (adv && v_r[S_VPR]);
  assign mem_wa = clearing ? clr_cnt_r[IDX_W-1:0] : pipe_r[S_VPR].idx;

  always_ff @(posedge clk) begin
    if (mem_we) m_mem[mem_wa] <= clearing ? 32'sd0 : m_new;
    if (adv) m_rd_r <= m_mem[pipe_r[S_VPR-1].idx];
  end

  always_ff @(posedge clk) begin
    if (mem_we) v_mem[mem_wa] <= clearing ? 48'd0 : v_new;
    if (adv) v_rd_r <= v_mem[pipe_r[S_VPR-1].idx];
  end

  always_comb begin
    logic [31:0]  ug;
    logic [62:0]  gsum;
    logic [41:0]  da, db;
    logic [65:0]  sa, sb;
    logic [33:0]  step;
    logic signed [34:0] nwf;
    logic signed [34:0] wx;

    pipe_nxt[0]     = '0;
    pipe_nxt[0].idx = in_data.param_index;
    pipe_nxt[0].g   = in_data.gradient;
    pipe_nxt[0].w   = in_data.weight;
    pipe_nxt[0].e   = {1'b0, in_data.step_number} + 21'd1;
    pipe_nxt[0].pr1 = ONE_Q;
    pipe_nxt[0].pr2 = ONE_Q;
    pipe_nxt[0].pb1 = b1_r;
    pipe_nxt[0].pb2 = b2_r;
    for (int k = 1; k < DEPTH; k++) pipe_nxt[k] = pipe_r[k-1];

    // beta^(t+1) by square and multiply, one exponent bit per stage
    for (int k = 1; k <= EXP_W; k++) begin
      if (pipe_r[k-1].e[k-1]) begin
        pipe_nxt[k].pr1 = mulq(pipe_r[k-1].pr1, pipe_r[k-1].pb1);
        pipe_nxt[k].pr2 = mulq(pipe_r[k-1].pr2, pipe_r[k-1].pb2);
      end
      pipe_nxt[k].pb1 = 24'(mulq({1'b0, pipe_r[k-1].pb1}, pipe_r[k-1].pb1));
      pipe_nxt[k].pb2 = 24'(mulq({1'b0, pipe_r[k-1].pb2}, pipe_r[k-1].pb2));
    end

    ug = pipe_r[0].g[31] ? 32'(-pipe_r[0].g) : pipe_r[0].g;
    pipe_nxt[1].gg  = {31'b0, ug} * {31'b0, ug};
    pipe_nxt[1].c1g = $signed({1'b0, c1}) * pipe_r[0].g;

    gsum = pipe_r[1].gg + 63'h8000;
    pipe_nxt[2].gsq = gsum[62:16];
    pipe_nxt[2].c1g = pipe_r[1].c1g + $signed({34'b0, HALF_Q});

    pipe_nxt[S_VPR].pvlo = {25'b0, c2} * {26'b0, pipe_r[2].gsq[23:0]} + {26'b0, HALF_Q};
    pipe_nxt[S_VPR].pvhi = {23'b0, c2} * {25'b0, pipe_r[2].gsq[46:24]};

    pipe_nxt[S_MOM].mn  = m_new;
    pipe_nxt[S_MOM].vn  = v_new;
    pipe_nxt[S_MOM].sat = mom_sat;

    pipe_nxt[S_ABS].neg = pipe_r[S_MOM].mn[31];
    pipe_nxt[S_ABS].am  = pipe_r[S_MOM].mn[31] ? 32'(-pipe_r[S_MOM].mn) : pipe_r[S_MOM].mn;

    // corrections and divider setup
    pipe_nxt[S_CORR].corr1 = ONE_Q - pipe_r[S_CORR-1].pr1;
    pipe_nxt[S_CORR].corr2 = ONE_Q - pipe_r[S_CORR-1].pr2;
    if (pipe_nxt[S_CORR].corr1 == '0) pipe_nxt[S_CORR].corr1 = 25'd1;
    if (pipe_nxt[S_CORR].corr2 == '0) pipe_nxt[S_CORR].corr2 = 25'd1;
    pipe_nxt[S_CORR].rem1 = '0;
    pipe_nxt[S_CORR].n1   = {pipe_r[S_CORR-1].am, 24'b0};
    pipe_nxt[S_CORR].q1   = '0;
    pipe_nxt[S_CORR].rem2 = {17'b0, pipe_r[S_CORR-1].vn[47:40]};
    pipe_nxt[S_CORR].n2   = {pipe_r[S_CORR-1].vn[39:0], 24'b0};
    pipe_nxt[S_CORR].q2   = '0;

    // vhat clips when the quotient needs more than 64 bits
    pipe_nxt[S_CORR+1].vsat = {17'b0, pipe_r[S_CORR].vn} >= {pipe_r[S_CORR].corr2, 40'b0};

    for (int k = S_CORR + 1; k <= S_CORR + D1_STG; k++) begin
      da = dstep({16'b0, pipe_r[k-1].rem1}, pipe_r[k-1].n1[55], {16'b0, pipe_r[k-1].corr1});
      db = dstep(da[41:1], pipe_r[k-1].n1[54], {16'b0, pipe_r[k-1].corr1});
      pipe_nxt[k].rem1 = db[25:1];
      pipe_nxt[k].n1   = {pipe_r[k-1].n1[53:0], 2'b00};
      pipe_nxt[k].q1   = {pipe_r[k-1].q1[53:0], da[0], db[0]};
    end

    for (int k = S_CORR + 1; k <= S_CORR + D2_STG; k++) begin
      da = dstep({16'b0, pipe_r[k-1].rem2}, pipe_r[k-1].n2[63], {16'b0, pipe_r[k-1].corr2});
      db = dstep(da[41:1], pipe_r[k-1].n2[62], {16'b0, pipe_r[k-1].corr2});
      pipe_nxt[k].rem2 = db[25:1];
      pipe_nxt[k].n2   = {pipe_r[k-1].n2[61:0], 2'b00};
      pipe_nxt[k].q2   = {pipe_r[k-1].q2[61:0], da[0], db[0]};
    end

    pipe_nxt[S_SQI].sqn  = pipe_r[S_SQI-1].vsat ? '1 : pipe_r[S_SQI-1].q2;
    pipe_nxt[S_SQI].rs   = '0;
    pipe_nxt[S_SQI].root = '0;
    pipe_nxt[S_SQI].phi  = {32'b0, lr_r} * {24'b0, pipe_r[S_SQI-1].q1[55:24]};
    pipe_nxt[S_SQI].plo  = {24'b0, lr_r} * {24'b0, pipe_r[S_SQI-1].q1[23:0]};

    pipe_nxt[S_SQI+1].a = {1'b0, pipe_r[S_SQI].phi} + {33'b0, pipe_r[S_SQI].plo[47:24]};

    for (int k = S_SQI + 1; k <= S_SQI + SQ_STG; k++) begin
      sa = sqstep(pipe_r[k-1].rs, pipe_r[k-1].root, pipe_r[k-1].sqn[63:62]);
      sb = sqstep(sa[65:32], sa[31:0], pipe_r[k-1].sqn[61:60]);
      pipe_nxt[k].rs   = sb[65:32];
      pipe_nxt[k].root = sb[31:0];
      pipe_nxt[k].sqn  = {pipe_r[k-1].sqn[59:0], 4'b0000};
    end

    pipe_nxt[S_DEN].den = {1'b0, pipe_r[S_DEN-1].root, 8'b0} + {17'b0, eps_r};
    if (pipe_nxt[S_DEN].den == '0) pipe_nxt[S_DEN].den = 41'd1;

    // step clips when a / den reaches 2^8
    pipe_nxt[S_SCMP].ssat = pipe_r[S_DEN].a >= {8'b0, pipe_r[S_DEN].den, 8'b0};
    pipe_nxt[S_SCMP].rem3 = pipe_r[S_DEN].a[48:8];
    pipe_nxt[S_SCMP].n3   = {pipe_r[S_DEN].a[7:0], 24'b0};
    pipe_nxt[S_SCMP].q3   = '0;

    for (int k = S_SCMP + 1; k <= S_SCMP + D3_STG; k++) begin
      da = dstep(pipe_r[k-1].rem3, pipe_r[k-1].n3[31], pipe_r[k-1].den);
      db = dstep(da[41:1], pipe_r[k-1].n3[30], pipe_r[k-1].den);
      pipe_nxt[k].rem3 = db[41:1];
      pipe_nxt[k].n3   = {pipe_r[k-1].n3[29:0], 2'b00};
      pipe_nxt[k].q3   = {pipe_r[k-1].q3[29:0], da[0], db[0]};
    end

    step = pipe_r[S_OUT-1].ssat ? {1'b1, 33'b0} >> 0 : {2'b00, pipe_r[S_OUT-1].q3};
    step = pipe_r[S_OUT-1].ssat ? 34'h2_0000_0000 : step;
    wx   = {{3{pipe_r[S_OUT-1].w[31]}}, pipe_r[S_OUT-1].w};
    nwf  = pipe_r[S_OUT-1].neg ? wx + $signed({1'b0, step}) : wx - $signed({1'b0, step});
    if (nwf[34:31] != 4'b0000 && nwf[34:31] != 4'b1111) begin
      pipe_nxt[S_OUT].nw  = nwf[34] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      pipe_nxt[S_OUT].sat = 1'b1;
    end else begin
      pipe_nxt[S_OUT].nw  = nwf[31:0];
    end
  end

endmodule

@@ hw/rtl/apu_checker.sv @@
// Port-level checks for the Adam parameter update block.
// Depends on apu_pkg for the result type; bound to the top level below.
module apu_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input apu_pkg::out_item_t out_data
);
  import apu_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a stalled result freezes the pipeline, so no request may enter
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("request accepted while result stalled");

  // the clearing pass blocks requests right after reset
  a_clear: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("request port open during clearing pass");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind adam_parameter_update apu_checker u_apu_checker (.*);

@@ sim/tb.sv @@
// Self-checking bench for adam_parameter_update: random and directed parameter requests,
// predicted in-bench with per-index moment stores. Depends on apu_pkg and the RTL top.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import apu_pkg::*;

  localparam longint QONE = 64'd1 << FRAC_BITS;
  localparam longint QHALF = 64'd1 << (FRAC_BITS - 1);
  localparam longint QMASK = QONE - 1;
  localparam int LATENCY = 90;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = CFG_BETA_FIRST;
  logic [CFG_W-1:0] cfg_wdata = '0;

  adam_parameter_update dut (.*);

  always #4 clk = ~clk;

  // predictor state
  logic [CFG_W-1:0] beta1_q, beta2_q, alpha_q, eps_q;
  logic signed [31:0] m_store [PARAM_COUNT];
  logic [47:0] v_store [PARAM_COUNT];

  in_item_t request_q[$];
  out_item_t weight_q[$];
  int errors = 0;
  int sender_idle = 0, recv_stall = 0;
  bit draining = 0;

  function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
    return (a * b + QHALF) >> FRAC_BITS;
  endfunction

  function automatic longint unsigned qpow(longint unsigned b, longint unsigned e);
    longint unsigned r;
    r = QONE;
    while (e != 0) begin
      if (e[0]) r = qmul(r, b);
      b = qmul(b, b);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x = x - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  function automatic out_item_t adam_update(in_item_t it);
    out_item_t res;
    longint g, w, s, mn, nw;
    longint unsigned b1, b2, c1, c2, e, ug, gsq, vo, lo, hi, vn, corr1, corr2;
    longint unsigned am, mh, vq, vr, vhat, den, a, q, r, f, stepv;
    bit sat, neg;
    int idx;
    idx = it.param_index;
    g = it.gradient;
    w = it.weight;
    e = 64'(it.step_number) + 1;
    b1 = beta1_q;
    b2 = beta2_q;
    c1 = QONE - b1;
    c2 = QONE - b2;
    sat = 0;
    s = longint'(b1) * longint'(m_store[idx]) + longint'(c1) * g + QHALF;
    mn = s >>> FRAC_BITS;
    if (mn > 64'sd2147483647) begin mn = 64'sd2147483647; sat = 1; end
    if (mn < -64'sd2147483648) begin mn = -64'sd2147483648; sat = 1; end
    m_store[idx] = 32'(mn);
    ug = g < 0 ? -g : g;
    gsq = (ug * ug + 64'h8000) >> 16;
    vo = v_store[idx];
    lo = b2 * (vo & QMASK) + c2 * (gsq & QMASK) + QHALF;
    hi = b2 * (vo >> FRAC_BITS) + c2 * (gsq >> FRAC_BITS);
    vn = hi + (lo >> FRAC_BITS);
    if (vn > 64'hFFFF_FFFF_FFFF) begin vn = 64'hFFFF_FFFF_FFFF; sat = 1; end
    v_store[idx] = 48'(vn);
    corr1 = QONE - qpow(b1, e);
    corr2 = QONE - qpow(b2, e);
    if (corr1 == 0) corr1 = 1;
    if (corr2 == 0) corr2 = 1;
    neg = mn < 0;
    am = neg ? -mn : mn;
    mh = (am << FRAC_BITS) / corr1;
    vq = vn / corr2;
    vr = vn % corr2;
    if (vq >= (64'd1 << (64 - FRAC_BITS))) vhat = '1;
    else vhat = (vq << FRAC_BITS) + (vr << FRAC_BITS) / corr2;
    den = (int_sqrt(vhat) << 8) + eps_q;
    if (den == 0) den = 1;
    a = alpha_q * (mh >> FRAC_BITS) + ((alpha_q * (mh & QMASK)) >> FRAC_BITS);
    q = a / den;
    r = a % den;
    if (q >= (64'd1 << (32 - FRAC_BITS))) begin
      stepv = 64'd1 << 33;
    end else begin
      f = 0;
      for (int i = 0; i < FRAC_BITS; i++) begin
        r = r << 1;
        f = f << 1;
        if (r >= den) begin r = r - den; f = f | 1; end
      end
      stepv = (q << FRAC_BITS) | f;
    end
    nw = neg ? w + longint'(stepv) : w - longint'(stepv);
    if (nw > 64'sd2147483647) begin nw = 64'sd2147483647; sat = 1; end
    if (nw < -64'sd2147483648) begin nw = -64'sd2147483648; sat = 1; end
    res.new_weight = 32'(nw);
    res.saturated = sat;
    return res;
  endfunction

  function automatic logic [CFG_W-1:0] beta_limit(logic [CFG_W-1:0] b);
    return b;  // 24-bit register can never reach one
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || !in_stall) begin
        if (request_q.size() != 0 && !draining && $urandom_range(99) >= sender_idle) begin
          in_valid <= 1'b1;
          in_data <= request_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall);
    end
  end

  // monitor: predict at acceptance, check results in order
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) weight_q = {weight_q, adam_update(in_data)};
    if (rst_n && out_valid && !out_stall) begin
      if (weight_q.size() == 0) begin
        report_mismatch("unexpected result", out_data.new_weight, 0);
      end else begin
        out_item_t want;
        want = weight_q.pop_front();
        if (out_data.new_weight !== want.new_weight)
          report_mismatch("new_weight", out_data.new_weight, want.new_weight);
        if (out_data.saturated !== want.saturated)
          report_mismatch("saturated", out_data.saturated, want.saturated);
      end
    end
  end

  task automatic add_request(int idx, int g, int w, int t);
    in_item_t it;
    it.param_index = IDX_W'(idx);
    it.gradient = g;
    it.weight = w;
    it.step_number = STEP_W'(t);
    request_q = {request_q, it};
  endtask

  task automatic drain();
    while (request_q.size() != 0 || in_valid || weight_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t ri, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= ri;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (ri)
      CFG_BETA_FIRST:    beta1_q = val;
      CFG_BETA_SECOND:   beta2_q = val;
      CFG_LEARNING_RATE: alpha_q = val;
      default:           eps_q = val;
    endcase
  endtask

  // mostly small index pool so moments build up and repeats hit forwarding
  task automatic random_requests(int n);
    int g;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: g = $urandom;
        1: g = $signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
        default: g = $signed($urandom_range(32'h2000_0000)) - 32'sh1000_0000;
      endcase
      add_request($urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(15), g,
                  $urandom_range(1) ? $urandom : $signed($urandom_range(32'h0800_0000)),
                  $urandom_range(3) == 0 ? $urandom_range(20'hFFFFF) : $urandom_range(40));
    end
  endtask

  initial begin
    logic [1:0] sel;
    beta1_q = BETA_FIRST_RST;
    beta2_q = BETA_SECOND_RST;
    alpha_q = LEARNING_RATE_RST;
    eps_q = EPSILON_TERM_RST;
    for (int i = 0; i < PARAM_COUNT; i++) begin
      m_store[i] = '0;
      v_store[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, zero gradient, huge steps, max step number
    add_request(0, 0, 0, 0);
    add_request(65535, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 20'hFFFFF);
    add_request(65535, 32'h8000_0000, 32'h8000_0000, 0);
    add_request(1, 32'h8000_0000, 32'h7FFF_FFFF, 1);
    add_request(1, 32'h8000_0000, 32'h7FFF_FFFF, 2);
    add_request(2, 32'h0100_0000, 32'h8000_0000, 0);
    add_request(2, -32'sh0100_0000, 32'h8000_0000, 5);
    add_request(3, 1, -1, 20'hFFFFF);
    add_request(3, -1, 1, 0);
    add_request(4, 32'h0000_0100, 0, 0);
    drain();

    // extreme settings: zero eps and zero betas, then maxima
    write_reg(CFG_EPSILON_TERM, 24'd0);
    write_reg(CFG_BETA_FIRST, 24'd0);
    write_reg(CFG_BETA_SECOND, 24'd0);
    write_reg(CFG_LEARNING_RATE, 24'hFFFFFF);
    add_request(5, 0, 123, 0);
    add_request(6, 32'h7FFF_FFFF, 0, 3);
    add_request(7, 32'h0000_0001, 32'h8000_0000, 0);
    drain();
    write_reg(CFG_BETA_FIRST, 24'hFFFFFF);
    write_reg(CFG_BETA_SECOND, 24'hFFFFFF);
    write_reg(CFG_EPSILON_TERM, 24'hFFFFFF);
    add_request(8, 32'h7FFF_FFFF, 0, 0);
    add_request(8, 32'h8000_0000, 0, 20'hFFFFF);
    add_request(9, 32'h0000_1000, 32'h7FFF_0000, 7);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      sel = ph[1:0];
      sender_idle = (sel == 1 || sel == 3) ? (sel == 1 ? 59 : 17) : 0;
      recv_stall = (sel == 2 || sel == 3) ? (sel == 2 ? 59 : 17) : 0;
      write_reg(CFG_BETA_FIRST, ph == 0 ? BETA_FIRST_RST : 24'($urandom));
      write_reg(CFG_BETA_SECOND, ph == 0 ? BETA_SECOND_RST : 24'($urandom));
      write_reg(CFG_LEARNING_RATE, ph == 0 ? LEARNING_RATE_RST : 24'($urandom));
      write_reg(CFG_EPSILON_TERM, ph[0] ? 24'($urandom_range(255)) : 24'($urandom));
      random_requests(50);
      // hold the sender until every result is back, then resume
      while (request_q.size() != 0) @(posedge clk);
      draining = 1;
      while (in_valid || weight_q.size() != 0) @(posedge clk);
      draining = 0;
      random_requests(50);
      drain();
    end

    if (errors == 0) begin
      $display("** adam_parameter_update: PASSED **");
    end else begin
      $display("** adam_parameter_update: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("** adam_parameter_update: FAILED **");
    $finish;
  end
endmodule
